@@ design/r2x_pkg.sv @@
package r2x_pkg;

	localparam int MaxWidth  = 512;
	localparam int LineSpan  = 2 * MaxWidth;
	localparam int ColW      = $clog2(LineSpan);
	localparam int SrcColW   = $clog2(MaxWidth);
	localparam int SrcRowW   = 10;
	localparam int CfgW      = 10;
	localparam int RowW      = 11;
	localparam int PixW      = 16;
	localparam int NumSlots  = 3;
	localparam int QDepth    = 4;
	localparam int QPtrW     = $clog2(QDepth);
	localparam int OutDataW  = 40;
	localparam logic [PixW-1:0] ChanMask = 16'h7BDE;

	localparam logic CfgWidth  = 1'b0;
	localparam logic CfgHeight = 1'b1;

	typedef enum logic [1:0] {
		PH_START,
		PH_UP,
		PH_LO,
		PH_EV
	} phase_t;

	// one accepted source pixel, classified
	typedef struct packed {
		logic [ColW-1:0]    col0;
		logic               two;
		logic [PixW-1:0]    val0;
		logic [PixW-1:0]    pix;
		logic [SrcRowW-1:0] row;
		logic               do_up;
		logic               do_lo;
		logic               sel_a;
		logic               sel_b;
		logic [1:0]         slot;
		logic               frame_end;
	} cmd_t;

	function automatic logic [PixW-1:0] avg2(input logic [PixW-1:0] a, input logic [PixW-1:0] b);
		logic [PixW:0] sum;
		sum = {1'b0, a & ChanMask} + {1'b0, b & ChanMask};
		return sum[PixW:1];
	endfunction

	function automatic logic [PixW-1:0] blend4(input logic [PixW-1:0] n1, input logic [PixW-1:0] n2,
		input logic [PixW-1:0] n3, input logic [PixW-1:0] n4);
		return avg2(avg2(n1, n2), avg2(n3, n4));
	endfunction

	function automatic logic [1:0] slot_add(input logic [1:0] s, input logic [1:0] d);
		logic [2:0] t;
		t = {1'b0, s} + {1'b0, d};
		return (t >= 3'(NumSlots)) ? 2'(t - 3'(NumSlots)) : t[1:0];
	endfunction

endpackage

@@ design/r2x_fifo.sv @@
module r2x_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  r2x_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output r2x_pkg::cmd_t dout,
	output logic          empty
);

	r2x_pkg::cmd_t mem_q [r2x_pkg::QDepth];
	logic [r2x_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [r2x_pkg::QPtrW:0]   cnt_q;

	assign full  = cnt_q == (r2x_pkg::QPtrW + 1)'(r2x_pkg::QDepth);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/r2x_front.sv @@
module r2x_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [r2x_pkg::CfgW-1:0]    src_width,
	input  logic [r2x_pkg::CfgW-1:0]    src_height,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [r2x_pkg::PixW-1:0]    s_tdata,
	output logic                        cmd_push,
	output r2x_pkg::cmd_t               cmd,
	input  logic                        cmd_full
);

	logic [r2x_pkg::SrcColW-1:0] col_q;
	logic [r2x_pkg::SrcRowW-1:0] row_q;
	logic [1:0]                  slot_q;
	logic [r2x_pkg::PixW-1:0]    prev0_q, prev1_q;

	logic [r2x_pkg::CfgW-1:0] w_eff, h_eff;
	logic                     last_row, col_end;
	logic [r2x_pkg::PixW-1:0] interp;

	assign s_tready = !cmd_full;
	assign cmd_push = s_tvalid && s_tready;

	always_comb begin
		w_eff = src_width;
		if (src_width > r2x_pkg::CfgW'(r2x_pkg::MaxWidth)) w_eff = r2x_pkg::CfgW'(r2x_pkg::MaxWidth);
		if (src_width < r2x_pkg::CfgW'(2)) w_eff = r2x_pkg::CfgW'(2);
		h_eff = (src_height < r2x_pkg::CfgW'(2)) ? r2x_pkg::CfgW'(2) : src_height;

		last_row = ({1'b0, row_q} + 11'd1) >= {1'b0, h_eff};
		col_end  = ({1'b0, col_q} + r2x_pkg::CfgW'(1)) >= w_eff;
		interp   = r2x_pkg::blend4(prev0_q, s_tdata, (col_q > 1) ? prev1_q : prev0_q, s_tdata);

		cmd.two       = col_q != '0;
		cmd.col0      = (col_q != '0) ? {col_q, 1'b0} - 1'b1 : {col_q, 1'b0};
		cmd.val0      = (col_q != '0) ? interp : s_tdata;
		cmd.pix       = s_tdata;
		cmd.row       = row_q;
		cmd.do_up     = row_q >= 2;
		cmd.do_lo     = last_row && row_q >= 1;
		cmd.sel_a     = row_q >= 4;
		cmd.sel_b     = row_q >= 3;
		cmd.slot      = slot_q;
		cmd.frame_end = col_end && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			prev0_q <= '0;
			prev1_q <= '0;
		end else if (cmd_push) begin
			prev1_q <= prev0_q;
			prev0_q <= s_tdata;
			if (col_end) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					slot_q <= r2x_pkg::slot_add(slot_q, 2'd1);
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

@@ design/r2x_back.sv @@
module r2x_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  r2x_pkg::cmd_t                 head,
	input  logic                          head_empty,
	output logic                          head_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [r2x_pkg::OutDataW-1:0]  m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);

	r2x_pkg::phase_t phase_q, ph, ph_next;
	logic            k_q;

	logic                     issue, step_end, out_ready, s1_ready;
	logic [r2x_pkg::ColW-1:0] iss_col;
	logic [r2x_pkg::PixW-1:0] iss_val;
	logic [r2x_pkg::RowW-1:0] iss_row;

	logic [r2x_pkg::PixW-1:0] mem_q [r2x_pkg::NumSlots][r2x_pkg::LineSpan];

	logic                     v_s1, last_s1, done_s1, sel_s1;
	r2x_pkg::phase_t          kind_s1;
	logic [r2x_pkg::ColW-1:0] col_s1;
	logic [r2x_pkg::RowW-1:0] row_s1;
	logic [r2x_pkg::PixW-1:0] val_s1;
	logic [1:0]               slot_s1;
	logic [r2x_pkg::PixW-1:0] rd_s1 [r2x_pkg::NumSlots];

	logic [r2x_pkg::PixW-1:0] ta, tb, tc, res;
	logic                     tvalid_q, tlast_q, tuser_q;
	logic [r2x_pkg::OutDataW-1:0] tdata_q;

	assign out_ready = !tvalid_q || m_tready;
	assign s1_ready  = !v_s1 || out_ready;
	assign issue     = !head_empty && s1_ready;

	// sequencer: upper odd row, lower odd row, even row; one column each step
	always_comb begin
		ph = phase_q;
		if (phase_q == r2x_pkg::PH_START) begin
			ph = head.do_up ? r2x_pkg::PH_UP : (head.do_lo ? r2x_pkg::PH_LO : r2x_pkg::PH_EV);
		end
		step_end = k_q == head.two;
		unique case (ph)
			r2x_pkg::PH_UP: ph_next = head.do_lo ? r2x_pkg::PH_LO : r2x_pkg::PH_EV;
			r2x_pkg::PH_LO: ph_next = r2x_pkg::PH_EV;
			default:        ph_next = r2x_pkg::PH_START;
		endcase
		head_pop = issue && step_end && ph == r2x_pkg::PH_EV;
		iss_col  = head.col0 + r2x_pkg::ColW'(k_q);
		iss_val  = k_q ? head.pix : head.val0;
		unique case (ph)
			r2x_pkg::PH_UP: iss_row = {head.row, 1'b0} - r2x_pkg::RowW'(3);
			r2x_pkg::PH_LO: iss_row = {head.row, 1'b0} - r2x_pkg::RowW'(1);
			default:        iss_row = {head.row, 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= r2x_pkg::PH_START;
			k_q     <= 1'b0;
		end else if (issue) begin
			if (step_end) begin
				phase_q <= ph_next;
				k_q     <= 1'b0;
			end else begin
				phase_q <= ph;
				k_q     <= 1'b1;
			end
		end
	end

	// line store: one bank per source row modulo three
	always_ff @(posedge clk) begin
		for (int b = 0; b < r2x_pkg::NumSlots; b++) begin
			if (issue) begin
				if (ph == r2x_pkg::PH_EV && head.slot == 2'(b)) begin
					mem_q[b][iss_col] <= iss_val;
				end
				rd_s1[b] <= mem_q[b][iss_col];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1 <= ph;
			col_s1  <= iss_col;
			row_s1  <= iss_row;
			val_s1  <= iss_val;
			sel_s1  <= (ph == r2x_pkg::PH_UP) ? head.sel_a : head.sel_b;
			slot_s1 <= head.slot;
			last_s1 <= step_end && ph == r2x_pkg::PH_EV;
			done_s1 <= step_end && ph == r2x_pkg::PH_EV && head.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= issue;
		end
	end

	always_comb begin
		ta = rd_s1[slot_s1];
		tb = rd_s1[r2x_pkg::slot_add(slot_s1, 2'd1)];
		tc = rd_s1[r2x_pkg::slot_add(slot_s1, 2'd2)];
		case (kind_s1)
			r2x_pkg::PH_UP: res = r2x_pkg::avg2(
				r2x_pkg::blend4(tb, tc, sel_s1 ? ta : tb, val_s1), '0);
			r2x_pkg::PH_LO: res = r2x_pkg::avg2(
				r2x_pkg::blend4(tc, val_s1, sel_s1 ? tb : tc, val_s1), '0);
			default:        res = val_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (out_ready) begin
			tvalid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && v_s1) begin
			tdata_q <= {3'b000, res, row_s1, col_s1};
			tlast_q <= last_s1;
			tuser_q <= done_s1;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;
	assign m_tuser  = tuser_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without run end");

	a_pop_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |=> phase_q == r2x_pkg::PH_START && !k_q)
		else $error("sequencer not restarted after pop");

	a_second_col: assert property (@(posedge clk) disable iff (!arst_n)
		k_q |-> phase_q != r2x_pkg::PH_START)
		else $error("second column without a phase");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_ready |=> v_s1 && $stable(col_s1) && $stable(row_s1))
		else $error("stage one lost under stall");

endmodule

@@ design/rgb555_two_x_upscaler.sv @@
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       s_tdata: pixel_in
// m_*       out  m_tvalid / m_tready       m_tdata: out_col, out_row, pixel_out;
//                                          m_tlast: run_last; m_tuser: frame_done
// cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One result leaves per cycle unless m_tready stalls it; a source pixel gives one to six
// results, about four on average, so the output sequencer sets the rate. The first result
// of a pixel passes through stage one and then the output register.
// The front takes pixels while the four-entry command queue has room.
// Reset clears counters, queue and pipeline; the line store is not cleared.
module rgb555_two_x_upscaler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [r2x_pkg::PixW-1:0]      s_tdata,    // [15:0] pixel_in
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [r2x_pkg::OutDataW-1:0]  m_tdata,    // [9:0] out_col, [20:10] out_row,
	                                                  // [36:21] pixel_out, rest zero
	output logic                          m_tlast,
	output logic                          m_tuser,    // [0] frame_done
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [r2x_pkg::CfgW-1:0]      cfg_data
);

	logic [r2x_pkg::CfgW-1:0] width_q, height_q;
	r2x_pkg::cmd_t            cmd, head;
	logic                     cmd_push, cmd_full, head_empty, head_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= r2x_pkg::CfgW'(320);
			height_q <= r2x_pkg::CfgW'(180);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				r2x_pkg::CfgWidth:  width_q  <= cfg_data;
				r2x_pkg::CfgHeight: height_q <= cfg_data;
				default:            width_q  <= width_q;
			endcase
		end
	end

	r2x_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_width  (width_q),
		.src_height (height_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cmd_push   (cmd_push),
		.cmd        (cmd),
		.cmd_full   (cmd_full)
	);

	r2x_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd),
		.full   (cmd_full),
		.pop    (head_pop),
		.dout   (head),
		.empty  (head_empty)
	);

	r2x_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

@@ tb/tb_rgb555_two_x_upscaler.sv @@
`timescale 1ns / 100ps

module tb_rgb555_two_x_upscaler;

	typedef struct packed {
		logic [9:0]  col;
		logic [10:0] row;
		logic [15:0] pix;
		logic        run_last;
		logic        frame_done;
	} out_pixel_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [r2x_pkg::PixW-1:0]     s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [r2x_pkg::OutDataW-1:0] m_tdata;
	logic                         m_tlast;
	logic                         m_tuser;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic                         cfg_index = r2x_pkg::CfgWidth;
	logic [r2x_pkg::CfgW-1:0]     cfg_data = '0;

	logic [15:0] src_queue[$];
	out_pixel_t  upscaled_queue[$];
	int          errors = 0;
	bit          calm = 1'b0;

	// predictor state
	logic [9:0]  width_reg = 10'd320;
	logic [9:0]  height_reg = 10'd180;
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic [15:0] last_pix = '0;
	logic [15:0] last_pix2 = '0;
	logic [15:0] line_mem[3][1024];

	rgb555_two_x_upscaler dut (.*);

	always #1 clk = ~clk;

	function automatic logic [15:0] mix2(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a & 16'h7BDE} + {1'b0, b & 16'h7BDE};
		return s[16:1];
	endfunction

	function automatic logic [15:0] mix4(input logic [15:0] a, input logic [15:0] b,
		input logic [15:0] c, input logic [15:0] d);
		return mix2(mix2(a, b), mix2(c, d));
	endfunction

	task automatic upscale_pixel(input logic [15:0] p);
		int unsigned w, h, c, r, n, k, sc, sm1, sm2;
		int unsigned cols[2];
		logic [15:0] vals[2];
		logic [15:0] a, b, cc, t3;
		bit lastrow;
		out_pixel_t burst[$];
		out_pixel_t o;
		w = width_reg;
		h = height_reg;
		if (w > r2x_pkg::MaxWidth) w = r2x_pkg::MaxWidth;
		if (w < 2) w = 2;
		if (h < 2) h = 2;
		c = (col_pos >= r2x_pkg::MaxWidth) ? r2x_pkg::MaxWidth - 1 : col_pos;
		r = row_pos;
		lastrow = (r + 1 >= h);
		n = 0;
		if (c > 0) begin
			cols[0] = 2 * c - 1;
			vals[0] = mix4(last_pix, p, (c > 1) ? last_pix2 : last_pix, p);
			n = 1;
		end
		cols[n] = 2 * c;
		vals[n] = p;
		n++;
		sc = r % 3;
		sm1 = (r + 2) % 3;
		sm2 = (r + 1) % 3;
		if (r >= 2) begin
			for (k = 0; k < n; k++) begin
				a = line_mem[sc][cols[k]];
				b = line_mem[sm2][cols[k]];
				cc = line_mem[sm1][cols[k]];
				t3 = (r - 2 > 1) ? a : b;
				o = '{10'(cols[k]), 11'(2 * r - 3), mix2(mix4(b, cc, t3, vals[k]), '0),
					1'b0, 1'b0};
				burst.push_back(o);
			end
		end
		if (lastrow && r >= 1) begin
			for (k = 0; k < n; k++) begin
				b = line_mem[sm2][cols[k]];
				cc = line_mem[sm1][cols[k]];
				t3 = (r - 1 > 1) ? b : cc;
				o = '{10'(cols[k]), 11'(2 * r - 1), mix2(mix4(cc, vals[k], t3, vals[k]), '0),
					1'b0, 1'b0};
				burst.push_back(o);
			end
		end
		for (k = 0; k < n; k++) begin
			burst.push_back('{10'(cols[k]), 11'(2 * r), vals[k], 1'b0, 1'b0});
			line_mem[sc][cols[k]] = vals[k];
		end
		last_pix2 = last_pix;
		last_pix = p;
		burst[burst.size() - 1].run_last = 1'b1;
		if (c + 1 >= w) begin
			col_pos = 0;
			if (lastrow) begin
				row_pos = 0;
				burst[burst.size() - 1].frame_done = 1'b1;
			end else begin
				row_pos = (r + 1) & 10'h3FF;
			end
		end else begin
			col_pos = c + 1;
		end
		foreach (burst[i]) upscaled_queue.push_back(burst[i]);
	endtask

	// source side
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			upscale_pixel(s_tdata);
		if (!s_tvalid || s_tready) begin
			if (src_queue.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
				s_tvalid <= 1'b1;
				s_tdata <= src_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side
	always @(posedge clk) begin
		out_pixel_t want, got;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata[9:0], m_tdata[20:10], m_tdata[36:21], m_tlast, m_tuser};
			if (upscaled_queue.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = upscaled_queue.pop_front();
				if (got !== want || m_tdata[r2x_pkg::OutDataW-1:37] !== '0) begin
					$display("%0t: expected col %0d row %0d pix %h last %b done %b",
						$time, want.col, want.row, want.pix, want.run_last, want.frame_done);
					$display("%0t: actual   col %0d row %0d pix %h last %b done %b tdata %h",
						$time, got.col, got.row, got.pix, got.run_last, got.frame_done, m_tdata);
					errors++;
				end
			end
		end
		m_tready <= calm || ($urandom_range(99) >= 9);
	end

	task automatic drain;
		while (src_queue.size() > 0 || s_tvalid || upscaled_queue.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == r2x_pkg::CfgWidth) width_reg = value;
		else height_reg = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// load a whole frame; configured size decides its pixel count
	task automatic run_frame(input logic [9:0] w, input logic [9:0] h, input bit directed);
		int unsigned ew, eh;
		logic [15:0] corners[4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
		drain();
		write_reg(r2x_pkg::CfgWidth, w);
		write_reg(r2x_pkg::CfgHeight, h);
		ew = (w > r2x_pkg::MaxWidth) ? r2x_pkg::MaxWidth : (w < 2 ? 2 : w);
		eh = (h < 2) ? 2 : h;
		for (int i = 0; i < ew * eh; i++)
			src_queue.push_back(directed ? corners[i % 4] : 16'($urandom));
	endtask

	initial begin
		int rand_items;
		logic [9:0] w, h;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_frame(10'd2, 10'd2, 1'b1);
		run_frame(10'd3, 10'd3, 1'b1);
		run_frame(10'd0, 10'd1, 1'b0);
		run_frame(10'd1, 10'd0, 1'b0);
		run_frame(10'd5, 10'd5, 1'b1);
		drain();
		calm = 1'b1;
		run_frame(10'd24, 10'd3, 1'b0);
		drain();
		calm = 1'b0;
		rand_items = 0;
		while (rand_items < 142) begin
			w = 10'($urandom_range(2, 12));
			h = 10'($urandom_range(2, 7));
			if ($urandom_range(9) == 0) w = 10'($urandom_range(0, 1));
			if ($urandom_range(9) == 0) h = 10'($urandom_range(0, 1));
			run_frame(w, h, 1'b0);
			rand_items += ((w < 2) ? 2 : w) * ((h < 2) ? 2 : h);
		end
		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
